// ===== rtl/core/hsl_rgb_pkg.sv =====
`timescale 1ns / 1ps

package hsl_rgb_pkg;

  // Field widths
  localparam int IN_W   = 14;   // signed input fields
  localparam int CH_W   = 13;   // unsigned 0..4096 channel values
  localparam int REM_W  = 10;   // remainder within a sector, 0..960
  localparam int CR_W   = CH_W + REM_W;
  localparam int Q_W    = 16;   // (c * rem) >> 6, at most 61440

  // Fixed-point constants
  localparam logic [CH_W-1:0] ONE_Q12    = 13'd4096;
  localparam logic [CH_W-1:0] HALF_Q12   = 13'd2048;
  localparam logic [CH_W-1:0] HUE_FULL   = 13'd5760;
  localparam logic [REM_W-1:0] HUE_SECTOR = 10'd960;

  // Divide by 960 as (v >> 6) / 15, the latter through a reciprocal
  localparam int PRE_SHIFT   = 6;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP_15 = 17'd69906;
  localparam int QK_W = Q_W + RECIP_W;

  // Hue sectors, 60 degrees each
  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_t;

  // Front end output: chroma, lightness, sector and position in sector
  typedef struct packed {
    logic              valid;
    logic [CH_W-1:0]   chroma;
    logic [CH_W-1:0]   light;
    logic [REM_W-1:0]  rem;
    sector_t           sector;
  } prep_t;

  // Second component stage output
  typedef struct packed {
    logic              valid;
    logic [CH_W-1:0]   chroma;
    logic [CH_W-1:0]   offset;
    logic [QK_W-1:0]   x_scaled;
    sector_t           sector;
  } xcomp_t;

endpackage

// ===== rtl/core/hsl_rgb_prep.sv =====
`timescale 1ns / 1ps

module hsl_rgb_prep (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [hsl_rgb_pkg::IN_W-1:0] hue,
  input  logic signed [hsl_rgb_pkg::IN_W-1:0] saturation,
  input  logic signed [hsl_rgb_pkg::IN_W-1:0] lightness,
  output hsl_rgb_pkg::prep_t                  prep
);

  localparam int CW = hsl_rgb_pkg::CH_W;
  localparam int RW = hsl_rgb_pkg::REM_W;
  localparam int IW = hsl_rgb_pkg::IN_W;

  // Stage A registers
  logic          a_valid;
  logic [CW-1:0] a_hue;
  logic [CW-1:0] a_sat;
  logic [CW-1:0] a_light;
  logic [CW-1:0] a_span;

  logic [CW-1:0] hue_next;
  logic [CW-1:0] sat_next;
  logic [CW-1:0] light_next;
  logic [CW-1:0] span_next;
  logic [IW-1:0] light_dbl;

  // Clamp a signed field to 0..4096
  function automatic logic [CW-1:0] clamp_unit(input logic signed [IW-1:0] v);
    logic [CW-1:0] r;
    if (v[IW-1]) begin
      r = '0;
    end else if (v[CW-1:0] > hsl_rgb_pkg::ONE_Q12) begin
      r = hsl_rgb_pkg::ONE_Q12;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // Apply hue rule, clamp, and form 4096 - |2L - 4096|
  always_comb begin
    if (hue[IW-1] || (hue[CW-1:0] >= hsl_rgb_pkg::HUE_FULL)) begin
      hue_next = '0;
    end else begin
      hue_next = hue[CW-1:0];
    end
    sat_next   = clamp_unit(saturation);
    light_next = clamp_unit(lightness);
    light_dbl  = {light_next, 1'b0};
    if (light_next < hsl_rgb_pkg::HALF_Q12) begin
      span_next = light_dbl[CW-1:0];
    end else begin
      span_next = CW'({1'b0, hsl_rgb_pkg::ONE_Q12, 1'b0} - light_dbl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_hue   <= hue_next;
    a_sat   <= sat_next;
    a_light <= light_next;
    a_span  <= span_next;
  end

  // Stage B: chroma product, sector search and remainder
  logic [2*CW-1:0] chroma_prod;
  logic [CW-1:0]   sec_base;
  logic [RW-1:0]   rem_raw;
  logic [RW-1:0]   rem_next;
  hsl_rgb_pkg::sector_t sector_next;

  always_comb begin
    chroma_prod = a_span * a_sat;
    if (a_hue >= CW'(5 * 960)) begin
      sector_next = hsl_rgb_pkg::SEC_MAG_RED;
      sec_base    = CW'(5 * 960);
    end else if (a_hue >= CW'(4 * 960)) begin
      sector_next = hsl_rgb_pkg::SEC_BLU_MAG;
      sec_base    = CW'(4 * 960);
    end else if (a_hue >= CW'(3 * 960)) begin
      sector_next = hsl_rgb_pkg::SEC_CYN_BLU;
      sec_base    = CW'(3 * 960);
    end else if (a_hue >= CW'(2 * 960)) begin
      sector_next = hsl_rgb_pkg::SEC_GRN_CYN;
      sec_base    = CW'(2 * 960);
    end else if (a_hue >= CW'(960)) begin
      sector_next = hsl_rgb_pkg::SEC_YEL_GRN;
      sec_base    = CW'(960);
    end else begin
      sector_next = hsl_rgb_pkg::SEC_RED_YEL;
      sec_base    = '0;
    end
    rem_raw = RW'(a_hue - sec_base);
    // odd sectors run backward
    if (sector_next[0]) begin
      rem_next = hsl_rgb_pkg::HUE_SECTOR - rem_raw;
    end else begin
      rem_next = rem_raw;
    end
  end

  // Advance the stage B register; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      prep.valid <= 1'b0;
    end else begin
      prep.valid <= a_valid;
    end
    prep.chroma <= chroma_prod[2*CW-2:CW-1];
    prep.light  <= a_light;
    prep.rem    <= rem_next;
    prep.sector <= sector_next;
  end

endmodule

// ===== rtl/core/hsl_rgb_xcomp.sv =====
`timescale 1ns / 1ps

module hsl_rgb_xcomp (
  input  logic                clk,
  input  logic                rst,
  input  hsl_rgb_pkg::prep_t  prep,
  output hsl_rgb_pkg::xcomp_t xc
);

  localparam int CW  = hsl_rgb_pkg::CH_W;
  localparam int CRW = hsl_rgb_pkg::CR_W;
  localparam int QW  = hsl_rgb_pkg::Q_W;
  localparam int PS  = hsl_rgb_pkg::PRE_SHIFT;

  // Stage C registers
  logic                 c_valid;
  logic [CW-1:0]        c_chroma;
  logic [CW-1:0]        c_offset;
  logic [CRW-1:0]       c_cr;
  hsl_rgb_pkg::sector_t c_sector;

  logic [QW-1:0] quot_in;

  // Stage C: chroma times position, and offset m = L - c/2
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= prep.valid;
    end
  end

  always_ff @(posedge clk) begin
    c_chroma <= prep.chroma;
    c_offset <= prep.light - {1'b0, prep.chroma[CW-1:1]};
    c_cr     <= prep.chroma * prep.rem;
    c_sector <= prep.sector;
  end

  // Stage D: divide by 960 as shift by 6, then reciprocal of 15
  assign quot_in = c_cr[QW+PS-1:PS];

  always_ff @(posedge clk) begin
    if (rst) begin
      xc.valid <= 1'b0;
    end else begin
      xc.valid <= c_valid;
    end
    xc.chroma   <= c_chroma;
    xc.offset   <= c_offset;
    xc.x_scaled <= quot_in * hsl_rgb_pkg::RECIP_15;
    xc.sector   <= c_sector;
  end

endmodule

// ===== rtl/core/hsl_rgb_mix.sv =====
`timescale 1ns / 1ps

module hsl_rgb_mix (
  input  logic                             clk,
  input  logic                             rst,
  input  hsl_rgb_pkg::xcomp_t              xc,
  output logic                             done,
  output logic [hsl_rgb_pkg::CH_W-1:0]     red,
  output logic [hsl_rgb_pkg::CH_W-1:0]     green,
  output logic [hsl_rgb_pkg::CH_W-1:0]     blue
);

  localparam int CW = hsl_rgb_pkg::CH_W;
  localparam int RS = hsl_rgb_pkg::RECIP_SHIFT;

  logic [CW-1:0] x_val;
  logic [CW-1:0] r_base;
  logic [CW-1:0] g_base;
  logic [CW-1:0] b_base;

  assign x_val = xc.x_scaled[RS+CW-1:RS];

  // Route chroma and second component by sector
  always_comb begin
    case (xc.sector)
      hsl_rgb_pkg::SEC_RED_YEL: begin
        r_base = xc.chroma; g_base = x_val;     b_base = '0;
      end
      hsl_rgb_pkg::SEC_YEL_GRN: begin
        r_base = x_val;     g_base = xc.chroma; b_base = '0;
      end
      hsl_rgb_pkg::SEC_GRN_CYN: begin
        r_base = '0;        g_base = xc.chroma; b_base = x_val;
      end
      hsl_rgb_pkg::SEC_CYN_BLU: begin
        r_base = '0;        g_base = x_val;     b_base = xc.chroma;
      end
      hsl_rgb_pkg::SEC_BLU_MAG: begin
        r_base = x_val;     g_base = '0;        b_base = xc.chroma;
      end
      default: begin
        r_base = xc.chroma; g_base = '0;        b_base = x_val;
      end
    endcase
  end

  // Add offset and present the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= xc.valid;
    end
  end

  always_ff @(posedge clk) begin
    red   <= r_base + xc.offset;
    green <= g_base + xc.offset;
    blue  <= b_base + xc.offset;
  end

endmodule

// ===== rtl/core/hsl_to_rgb_convert.sv =====
`timescale 1ns / 1ps

// Channel  | Signals                          | Transfer
// ---------+----------------------------------+-------------------------------
// pixel in | start, busy, hue, saturation,    | clock edge with start high and
//          | lightness                        | busy low
// pixel out| done, red, green, blue           | clock edge ending a cycle with
//          |                                  | done high
//
// One pixel is taken every cycle while busy is low; each result passes through the
// stage registers in order (clamp, chroma product, position product, reciprocal
// product, channel mix and offset add) before it reaches the outputs.
// Reset (rst, synchronous) drops every item in flight; busy is high only
// while rst is held. The receiver cannot stall, so the pipeline never holds.

module hsl_to_rgb_convert (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [hsl_rgb_pkg::IN_W-1:0] hue,
  input  logic signed [hsl_rgb_pkg::IN_W-1:0] saturation,
  input  logic signed [hsl_rgb_pkg::IN_W-1:0] lightness,
  output logic                                done,
  output logic [hsl_rgb_pkg::CH_W-1:0]        red,
  output logic [hsl_rgb_pkg::CH_W-1:0]        green,
  output logic [hsl_rgb_pkg::CH_W-1:0]        blue
);

  hsl_rgb_pkg::prep_t  prep;
  hsl_rgb_pkg::xcomp_t xc;
  logic                in_valid;

  // Refuse transfers while reset is held
  assign busy     = rst;
  assign in_valid = start & ~busy;

  hsl_rgb_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .prep       (prep)
  );

  hsl_rgb_xcomp u_xcomp (
    .clk  (clk),
    .rst  (rst),
    .prep (prep),
    .xc   (xc)
  );

  hsl_rgb_mix u_mix (
    .clk   (clk),
    .rst   (rst),
    .xc    (xc),
    .done  (done),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

endmodule
